/* design/dur_pkg.sv */
package dur_pkg;

  // Width of the accumulator and the running total; overflow past this width is an error.
  localparam int TOTAL_BITS = 31;
  // Width of the elapsed_sec result field.
  localparam int OUT_BITS   = 31;
  localparam int CHAR_BITS  = 8;
  localparam int SCALE_BITS = 12;

  localparam logic [CHAR_BITS-1:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [CHAR_BITS-1:0] CH_NINE = 8'h39;  // '9'
  localparam logic [CHAR_BITS-1:0] CH_H    = 8'h68;  // 'h'
  localparam logic [CHAR_BITS-1:0] CH_M    = 8'h6D;  // 'm'
  localparam logic [CHAR_BITS-1:0] CH_S    = 8'h73;  // 's'

  localparam logic [SCALE_BITS-1:0] SCALE_H = 12'd3600;
  localparam logic [SCALE_BITS-1:0] SCALE_M = 12'd60;
  localparam logic [SCALE_BITS-1:0] SCALE_S = 12'd1;

endpackage

/* design/dur_ifs.sv */
interface dur_in_if import dur_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_code;
  logic                 end_marker;

  modport source (output valid, output char_code, output end_marker, input ready);
  modport sink   (input valid, input char_code, input end_marker, output ready);
endinterface

interface dur_out_if import dur_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                ok;
  logic [OUT_BITS-1:0] elapsed_sec;

  modport source (output valid, output ok, output elapsed_sec, input ready);
  modport sink   (input valid, input ok, input elapsed_sec, output ready);
endinterface

/* design/duration_string_parser_top.sv */
// Duration string parser. Send a string such as 1h30m15s one byte per request on in_ch,
// then one request with end_marker set; that terminator, and only it, produces one
// result on out_ch: ok=1 with the total in seconds, or ok=0 with a zero total for an
// empty string, a non-digit where a digit belongs, an unknown unit letter, a number
// with no unit, a repeated unit, or a value past 2^31-1. All state clears after each
// terminator. Throughput is one request per cycle: each byte is captured in an input
// register and folded into the parser state in the next cycle by a constant multiply
// and one add/compare, so a new byte enters every cycle. An accepted terminator goes
// through the input register, then the result register, which lets input continue
// while a result waits; only a second terminator stalls behind an untaken result.
module duration_string_parser_top import dur_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  dur_in_if.sink       in_ch,
  dur_out_if.source    out_ch
);

  typedef enum logic [1:0] {
    PH_START,
    PH_AFTER_UNIT,
    PH_IN_NUMBER
  } phase_t;

  // Input stage
  logic                 s1_valid_r, s1_valid_nxt;
  logic [CHAR_BITS-1:0] s1_char_r;
  logic                 s1_end_r;
  logic                 s1_fire;
  logic                 out_free;

  // Parser state
  logic [TOTAL_BITS-1:0] accum_r, accum_nxt;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  phase_t                phase_r, phase_nxt;
  logic                  hours_r, hours_nxt;
  logic                  minutes_r, minutes_nxt;
  logic                  seconds_r, seconds_nxt;
  logic                  err_r, err_nxt;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [OUT_BITS-1:0] out_total_r, out_total_nxt;

  // Datapath
  logic                    is_digit;
  logic [3:0]              digit;
  logic [TOTAL_BITS+3:0]   accum_x10;
  logic                    digit_ovf;
  logic [SCALE_BITS-1:0]   scale;
  logic                    is_unit;
  logic                    unit_used;
  logic [TOTAL_BITS+12:0]  unit_sum;
  logic                    unit_ovf;
  logic                    good;

  // A terminator needs the result slot; characters never do.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && (!s1_end_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_ok_r;
  assign out_ch.elapsed_sec = out_total_r;

  assign is_digit  = (s1_char_r >= CH_ZERO) && (s1_char_r <= CH_NINE);
  assign digit     = 4'(s1_char_r - CH_ZERO);
  // accum*10 + d > limit is the same test as accum > (limit - d) / 10.
  assign accum_x10 = ((TOTAL_BITS+4)'(accum_r) << 3) + ((TOTAL_BITS+4)'(accum_r) << 1)
                   + (TOTAL_BITS+4)'(digit);
  assign digit_ovf = |accum_x10[TOTAL_BITS+3:TOTAL_BITS];

  // Decode the unit letter into its scale and its used flag.
  always_comb begin
    unique case (s1_char_r)
      CH_H: begin
        scale     = SCALE_H;
        is_unit   = 1'b1;
        unit_used = hours_r;
      end
      CH_M: begin
        scale     = SCALE_M;
        is_unit   = 1'b1;
        unit_used = minutes_r;
      end
      CH_S: begin
        scale     = SCALE_S;
        is_unit   = 1'b1;
        unit_used = seconds_r;
      end
      default: begin
        scale     = '0;
        is_unit   = 1'b0;
        unit_used = 1'b0;
      end
    endcase
  end

  // accum*scale + total > limit is the same test as accum > (limit - total) / scale.
  assign unit_sum = (TOTAL_BITS+13)'(accum_r) * (TOTAL_BITS+13)'(scale)
                  + (TOTAL_BITS+13)'(total_r);
  assign unit_ovf = |unit_sum[TOTAL_BITS+12:TOTAL_BITS];

  assign good = !err_r && (phase_r == PH_AFTER_UNIT);

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    accum_nxt     = accum_r;
    total_nxt     = total_r;
    phase_nxt     = phase_r;
    hours_nxt     = hours_r;
    minutes_nxt   = minutes_r;
    seconds_nxt   = seconds_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_total_nxt = out_total_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_ch.ready) begin
      s1_valid_nxt = in_ch.valid;
    end

    if (s1_fire) begin
      if (s1_end_r) begin
        // Report, then clear for the next string.
        out_valid_nxt = 1'b1;
        out_ok_nxt    = good;
        out_total_nxt = good ? OUT_BITS'(total_r) : '0;
        accum_nxt     = '0;
        total_nxt     = '0;
        phase_nxt     = PH_START;
        hours_nxt     = 1'b0;
        minutes_nxt   = 1'b0;
        seconds_nxt   = 1'b0;
        err_nxt       = 1'b0;
      end else if (!err_r) begin
        if (is_digit) begin
          if (digit_ovf) begin
            err_nxt = 1'b1;
          end else begin
            accum_nxt = accum_x10[TOTAL_BITS-1:0];
            phase_nxt = PH_IN_NUMBER;
          end
        end else if (phase_r != PH_IN_NUMBER || !is_unit || unit_used || unit_ovf) begin
          // Missing digit, unknown suffix, repeated unit or overflow.
          err_nxt = 1'b1;
        end else begin
          total_nxt = unit_sum[TOTAL_BITS-1:0];
          accum_nxt = '0;
          phase_nxt = PH_AFTER_UNIT;
          if (s1_char_r == CH_H) hours_nxt   = 1'b1;
          if (s1_char_r == CH_M) minutes_nxt = 1'b1;
          if (s1_char_r == CH_S) seconds_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      accum_r     <= '0;
      total_r     <= '0;
      phase_r     <= PH_START;
      hours_r     <= 1'b0;
      minutes_r   <= 1'b0;
      seconds_r   <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      accum_r     <= accum_nxt;
      total_r     <= total_nxt;
      phase_r     <= phase_nxt;
      hours_r     <= hours_nxt;
      minutes_r   <= minutes_nxt;
      seconds_r   <= seconds_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_char_r <= in_ch.char_code;
      s1_end_r  <= in_ch.end_marker;
    end
    out_ok_r    <= out_ok_nxt;
    out_total_r <= out_total_nxt;
  end

`ifndef ASSERT_OFF
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_end_r |=> phase_r == PH_START && total_r == '0 && !err_r)
    else $error("parser state not cleared after terminator");

  a_error_freezes_total: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !s1_end_r && err_r |=> $stable(total_r) && err_r)
    else $error("running total changed after an error");

  a_used_implies_started: assert property (@(posedge clk) disable iff (!rst_n)
    hours_r || minutes_r || seconds_r |-> phase_r != PH_START)
    else $error("unit flag set while no characters seen");

  a_bad_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> out_total_r == '0)
    else $error("nonzero total reported with error");

  a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !s1_fire || !s1_end_r)
    else $error("terminator processed over an untaken result");
`endif

endmodule
